>>> src/hpdc_pkg.sv
// ----------------------------------------------------------------------------
// hpdc_pkg: shared constants and tables for the heading PID drive controller
// Holds the serial divider sizes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package hpdc_pkg;

   // serial divider: dividend magnitude, divisor and step counter widths
   localparam int DIV_DVD_W = 63;
   localparam int DIV_DVS_W = 32;
   localparam int DIV_CNT_W = 6;

   // CORDIC vectoring steps and angle table width (Q16 degrees)
   localparam int CORDIC_STEPS = 20;
   localparam int ATAN_W       = 22;

   // arctangent of 2^-i in Q16 degrees
   function automatic logic [ATAN_W-1:0] cordic_atan(input logic [4:0] idx);
      logic [ATAN_W-1:0] val;
      case (idx)
         5'd0:    val = 22'd2949120;
         5'd1:    val = 22'd1740967;
         5'd2:    val = 22'd919879;
         5'd3:    val = 22'd466945;
         5'd4:    val = 22'd234379;
         5'd5:    val = 22'd117304;
         5'd6:    val = 22'd58666;
         5'd7:    val = 22'd29335;
         5'd8:    val = 22'd14668;
         5'd9:    val = 22'd7334;
         5'd10:   val = 22'd3667;
         5'd11:   val = 22'd1833;
         5'd12:   val = 22'd917;
         5'd13:   val = 22'd458;
         5'd14:   val = 22'd229;
         5'd15:   val = 22'd115;
         5'd16:   val = 22'd57;
         5'd17:   val = 22'd29;
         5'd18:   val = 22'd14;
         5'd19:   val = 22'd7;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> src/hpdc_divider.sv
// ----------------------------------------------------------------------------
// hpdc_divider: unsigned restoring divider
// One quotient bit per cycle; a start pulse loads the operands and done
// pulses once the quotient is complete.
// ----------------------------------------------------------------------------
module hpdc_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [hpdc_pkg::DIV_DVD_W-1:0] dividend,
   input  logic [hpdc_pkg::DIV_DVS_W-1:0] divisor,
   output logic                           done,
   output logic [hpdc_pkg::DIV_DVD_W-1:0] quotient
);
   import hpdc_pkg::*;

   localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_DVD_W - 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic [DIV_DVS_W-1:0]  rem_ff;
   logic [DIV_DVS_W-1:0]  dvs_ff;
   logic [DIV_DVD_W-1:0]  quo_ff;

   logic [DIV_DVS_W:0]    rem_shift;
   logic                  fits;
   logic [DIV_DVS_W:0]    rem_diff;
   logic [DIV_DVS_W-1:0]  rem_in;

   // trial subtract of the divisor from the shifted remainder
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIV_DVD_W-1]};
      fits      = rem_shift >= {1'b0, dvs_ff};
      rem_diff  = rem_shift - {1'b0, dvs_ff};
      rem_in    = fits ? rem_diff[DIV_DVS_W-1:0] : rem_shift[DIV_DVS_W-1:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath: dividend shifts out the top while quotient bits enter below
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvs_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DIV_DVD_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> src/heading_pid_drive_controller_unit.sv
// ----------------------------------------------------------------------------
// heading_pid_drive_controller_unit: heading PID and differential drive mixer
// Per pose request: bearing to the target by CORDIC, folded heading error,
// PID turn command, distance-based drive and motor duty/direction mapping.
// ----------------------------------------------------------------------------
//  channel | dir | fields (lowest bits first)
//  req_*   | in  | pos_x 24s, pos_z 24s, heading 16u, timestamp_us 32u
//  rsp_*   | out | left_duty 10, left_reverse 1, right_duty 10,
//          |     | right_reverse 1, heading_error 9s, stopped 1
//  csr_*   | in  | index 0..5: gains p/i/d, drive gain, target x, target y
//
// A request runs through the sequencer steps, 20 CORDIC steps and a pass of
// the shared serial divider (a start step, then waits for done) for the
// integral term. A nonzero interval adds a second divider pass for the
// derivative term, and driving adds 25 square-root steps plus two drive
// steps. req_tready is high only while idle. The response is loaded into
// the output register as the sequencer returns to idle; an earlier response
// not yet taken holds the sequencer until the register frees up.
// Reset is synchronous and restores register defaults and clears PID state.
// ----------------------------------------------------------------------------
module heading_pid_drive_controller_unit #(
   parameter int DUTY_FLOOR = 150,
   parameter int DUTY_MAX   = 512
) (
   input  logic        clock,
   input  logic        reset,
   // pos_x[23:0], pos_z[47:24], heading[63:48], timestamp_us[95:64]
   input  logic [95:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // left_duty[9:0], left_reverse[10], right_duty[20:11], right_reverse[21],
   // heading_error[30:22], stopped[31]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import hpdc_pkg::*;

   typedef enum logic [20:0] {
      S_IDLE       = 21'h000001,
      S_PREP       = 21'h000002,
      S_CORDIC     = 21'h000004,
      S_ANGLE      = 21'h000008,
      S_ERROR      = 21'h000010,
      S_SQ_X       = 21'h000020,
      S_SQ_Y       = 21'h000040,
      S_PID_MUL    = 21'h000080,
      S_PID_ACC    = 21'h000100,
      S_PROD_LO    = 21'h000200,
      S_PROD_HI    = 21'h000400,
      S_DIVI_GO    = 21'h000800,
      S_DIVI_WAIT  = 21'h001000,
      S_DIVD_GO    = 21'h002000,
      S_DIVD_WAIT  = 21'h004000,
      S_TURN       = 21'h008000,
      S_SQRT       = 21'h010000,
      S_DRIVE_MUL  = 21'h020000,
      S_DRIVE_CLIP = 21'h040000,
      S_MIX        = 21'h080000,
      S_OUT        = 21'h100000
   } state_type;

   typedef enum logic [2:0] {
      REG_GAIN_P   = 3'd0,
      REG_GAIN_I   = 3'd1,
      REG_GAIN_D   = 3'd2,
      REG_GAIN_DRV = 3'd3,
      REG_TARGET_X = 3'd4,
      REG_TARGET_Y = 3'd5
   } csr_reg_type;

   localparam logic signed [11:0] DUTY_BASE = 12'(DUTY_FLOOR);
   localparam logic signed [11:0] DUTY_SPAN = 12'(DUTY_MAX - DUTY_FLOOR);
   localparam logic [4:0]  CORDIC_LAST = 5'(CORDIC_STEPS - 1);
   localparam logic [4:0]  SQRT_LAST   = 5'd24;
   localparam logic signed [47:0] INTEG_MAX = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] INTEG_MIN = {1'b1, {47{1'b0}}};
   localparam logic [49:0] NEAR_LIMIT = 50'd1717986;

   // {reverse, duty[9:0]} for a mixed command of -512..512
   function automatic logic [10:0] motor_map(input logic signed [10:0] cmd);
      logic [10:0]        mag;
      logic signed [23:0] prod;
      logic signed [23:0] part;
      logic signed [23:0] duty;
      mag  = cmd[10] ? 11'(-cmd) : cmd;
      prod = $signed({1'b0, mag}) * DUTY_SPAN;
      part = prod[23] ? ((prod + 24'sd511) >>> 9) : (prod >>> 9);
      duty = part + 24'(DUTY_BASE);
      return {cmd[10] && (duty != 0), duty[9:0]};
   endfunction

   // registers
   state_type          state_ff, state_in;
   logic signed [15:0] gain_p_ff, gain_i_ff, gain_d_ff, gain_drv_ff;
   logic signed [23:0] target_x_ff, target_y_ff;
   logic signed [47:0] integ_ff;
   logic signed [8:0]  prev_err_ff;
   logic [31:0]        last_us_ff;

   logic signed [24:0] dx_ff, dy_ff;
   logic signed [16:0] hd_ff;
   logic [31:0]        ts_ff;
   logic signed [57:0] cx_ff, cy_ff;
   logic signed [24:0] cz_ff;
   logic [4:0]         iter_ff;
   logic signed [15:0] bearing_ff;
   logic signed [8:0]  err_ff;
   logic               aligned_ff;
   logic [31:0]        dt_ff;
   logic [49:0]        sq_ff;
   logic signed [41:0] errdt_ff;
   logic signed [24:0] pterm_ff;
   logic signed [25:0] dd_ff;
   logic signed [46:0] dnum_ff;
   logic signed [63:0] prod_ff;
   logic signed [47:0] iterm_ff, dterm_ff;
   logic signed [10:0] turn_ff;
   logic               stop_ff;
   logic [49:0]        sqsh_ff;
   logic [24:0]        root_ff;
   logic [26:0]        rem_ff;
   logic signed [42:0] vprod_ff;
   logic signed [10:0] drive_ff;
   logic signed [10:0] lmix_ff, rmix_ff;
   logic               rsp_tvalid_ff;
   logic [31:0]        rsp_tdata_ff;

   // combinational
   logic               req_fire;
   logic               out_free;
   logic [23:0]        in_pos_x, in_pos_z;
   logic [15:0]        in_heading;
   logic [31:0]        in_ts;
   logic signed [24:0] dx_acc, dy_acc;
   logic signed [16:0] hd_acc;
   logic [24:0]        ax, ay;
   logic signed [57:0] shx, shy;
   logic signed [24:0] atan_ext;
   logic [22:0]        zc;
   logic [23:0]        zr;
   logic [13:0]        base_a;
   logic signed [15:0] a16;
   logic               x_nonneg, y_nonneg;
   logic signed [15:0] bearing_acc;
   logic signed [17:0] dif;
   logic signed [17:0] dif_off;
   logic [9:0]         quo_deg, rem_deg;
   logic [9:0]         err_wide;
   logic signed [24:0] sq_op;
   logic signed [49:0] sq_prod;
   logic signed [9:0]  de;
   logic signed [48:0] isum;
   logic signed [40:0] prod_lo;
   logic signed [39:0] prod_hi;
   logic [62:0]        prod_mag;
   logic signed [46:0] dnum_abs;
   logic               div_start;
   logic               div_done;
   logic [62:0]        div_dvd;
   logic [31:0]        div_dvs;
   logic [62:0]        div_q;
   logic signed [47:0] q_signed;
   logic               q_neg;
   logic signed [49:0] tsum;
   logic signed [10:0] turn_acc;
   logic [28:0]        remsh, rtest;
   logic               rfit;
   logic [28:0]        rdiff;
   logic signed [41:0] vmul;
   logic signed [26:0] vclip;
   logic signed [26:0] vtrunc;
   logic signed [11:0] lsum, rsum;
   logic [10:0]        lmot, rmot;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign in_pos_x   = req_tdata[23:0];
   assign in_pos_z   = req_tdata[47:24];
   assign in_heading = req_tdata[63:48];
   assign in_ts      = req_tdata[95:64];

   // offsets to the target and heading fold at accept
   always_comb begin
      dx_acc = $signed({in_pos_x[23], in_pos_x}) - $signed({target_x_ff[23], target_x_ff});
      dy_acc = $signed({in_pos_z[23], in_pos_z}) - $signed({target_y_ff[23], target_y_ff});
      if (in_heading > 16'd23040) begin
         hd_acc = $signed({1'b0, in_heading}) - 17'sd46080;
      end else begin
         hd_acc = $signed({1'b0, in_heading});
      end
   end

   // CORDIC vectoring step
   always_comb begin
      ax       = dy_ff[24] ? 25'(-dy_ff) : dy_ff;
      ay       = dx_ff[24] ? 25'(-dx_ff) : dx_ff;
      shx      = cx_ff >>> iter_ff;
      shy      = cy_ff >>> iter_ff;
      atan_ext = $signed({3'b000, cordic_atan(iter_ff)});
   end

   // base angle, quadrant and bearing
   always_comb begin
      if (cz_ff < 0) begin
         zc = '0;
      end else if (cz_ff > 25'sd5898240) begin
         zc = 23'd5898240;
      end else begin
         zc = cz_ff[22:0];
      end
      zr = ({1'b0, zc} + 24'd256) >> 9;
      if (dx_ff == 0) begin
         base_a = '0;
      end else if (dy_ff == 0) begin
         base_a = 14'd11520;
      end else begin
         base_a = zr[13:0];
      end
      a16      = $signed({2'b00, base_a});
      x_nonneg = dy_ff[24] || (dy_ff == 0);
      y_nonneg = dx_ff[24] || (dx_ff == 0);
      if (x_nonneg) begin
         bearing_acc = y_nonneg ? a16 : -a16;
      end else begin
         bearing_acc = y_nonneg ? (16'sd23040 - a16) : (a16 - 16'sd23040);
      end
   end

   // whole-degree error folded to -180..179
   always_comb begin
      dif     = $signed({{2{bearing_ff[15]}}, bearing_ff}) - $signed({hd_ff[16], hd_ff});
      dif_off = dif + 18'sd69120;
      quo_deg = dif_off[16:7];
      if (quo_deg >= 10'd720) begin
         rem_deg = quo_deg - 10'd720;
      end else if (quo_deg >= 10'd360) begin
         rem_deg = quo_deg - 10'd360;
      end else begin
         rem_deg = quo_deg;
      end
      err_wide = rem_deg - 10'd180;
   end

   // squares for the distance, integral update, integral product halves
   always_comb begin
      sq_op    = (state_ff == S_SQ_X) ? dx_ff : dy_ff;
      sq_prod  = sq_op * sq_op;
      de       = $signed({err_ff[8], err_ff}) - $signed({prev_err_ff[8], prev_err_ff});
      isum     = $signed({integ_ff[47], integ_ff}) + $signed({{7{errdt_ff[41]}}, errdt_ff});
      prod_lo  = gain_i_ff * $signed({1'b0, integ_ff[23:0]});
      prod_hi  = gain_i_ff * $signed(integ_ff[47:24]);
   end

   // shared divider operands and signed quotient
   always_comb begin
      prod_mag  = prod_ff[63] ? 63'(-prod_ff) : prod_ff[62:0];
      dnum_abs  = dnum_ff[46] ? -dnum_ff : dnum_ff;
      div_start = (state_ff == S_DIVI_GO) || (state_ff == S_DIVD_GO);
      if (state_ff == S_DIVD_GO) begin
         div_dvd = {16'b0, dnum_abs};
         div_dvs = dt_ff;
      end else begin
         div_dvd = prod_mag;
         div_dvs = 32'd1000000;
      end
      q_neg    = (state_ff == S_DIVD_WAIT) ? dnum_ff[46] : prod_ff[63];
      q_signed = q_neg ? -$signed({1'b0, div_q[46:0]}) : $signed({1'b0, div_q[46:0]});
   end

   // turn command sum and clamp
   always_comb begin
      tsum = $signed({{25{pterm_ff[24]}}, pterm_ff})
           + $signed({{2{iterm_ff[47]}}, iterm_ff})
           + $signed({{2{dterm_ff[47]}}, dterm_ff});
      if (tsum > 50'sd512) begin
         turn_acc = 11'sd512;
      end else if (tsum < -50'sd512) begin
         turn_acc = -11'sd512;
      end else begin
         turn_acc = tsum[10:0];
      end
   end

   // square root digit step, drive scaling
   always_comb begin
      remsh = {rem_ff, sqsh_ff[49:48]};
      rtest = {2'b00, root_ff, 2'b01};
      rfit  = remsh >= rtest;
      rdiff = remsh - rtest;
      vmul  = gain_drv_ff * $signed({1'b0, root_ff});
      if (vprod_ff > 43'sd33554432) begin
         vclip = 27'sd33554432;
      end else if (vprod_ff < -43'sd33554432) begin
         vclip = -27'sd33554432;
      end else begin
         vclip = vprod_ff[26:0];
      end
      vtrunc = vclip[26] ? ((vclip + 27'sd65535) >>> 16) : (vclip >>> 16);
   end

   // motor mix and duty mapping
   always_comb begin
      lsum = $signed({drive_ff[10], drive_ff}) + $signed({turn_ff[10], turn_ff});
      rsum = $signed({drive_ff[10], drive_ff}) - $signed({turn_ff[10], turn_ff});
      lmot = motor_map(lmix_ff);
      rmot = motor_map(rmix_ff);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:       if (req_fire) state_in = S_PREP;
         S_PREP:       state_in = S_CORDIC;
         S_CORDIC:     if (iter_ff == CORDIC_LAST) state_in = S_ANGLE;
         S_ANGLE:      state_in = S_ERROR;
         S_ERROR:      state_in = S_SQ_X;
         S_SQ_X:       state_in = S_SQ_Y;
         S_SQ_Y:       state_in = S_PID_MUL;
         S_PID_MUL:    state_in = S_PID_ACC;
         S_PID_ACC:    state_in = S_PROD_LO;
         S_PROD_LO:    state_in = S_PROD_HI;
         S_PROD_HI:    state_in = S_DIVI_GO;
         S_DIVI_GO:    state_in = S_DIVI_WAIT;
         S_DIVI_WAIT: begin
            if (div_done) state_in = (dt_ff != 0) ? S_DIVD_GO : S_TURN;
         end
         S_DIVD_GO:    state_in = S_DIVD_WAIT;
         S_DIVD_WAIT:  if (div_done) state_in = S_TURN;
         S_TURN: begin
            state_in = (aligned_ff && (sq_ff > NEAR_LIMIT)) ? S_SQRT : S_MIX;
         end
         S_SQRT:       if (iter_ff == SQRT_LAST) state_in = S_DRIVE_MUL;
         S_DRIVE_MUL:  state_in = S_DRIVE_CLIP;
         S_DRIVE_CLIP: state_in = S_MIX;
         S_MIX:        state_in = S_OUT;
         S_OUT:        if (out_free) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   // control state, configuration and loop memory
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         gain_p_ff     <= 16'sd10;
         gain_i_ff     <= 16'sd0;
         gain_d_ff     <= 16'sd1;
         gain_drv_ff   <= 16'sd20;
         target_x_ff   <= 24'sd0;
         target_y_ff   <= 24'sd32768;
         integ_ff      <= '0;
         prev_err_ff   <= '0;
         last_us_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_GAIN_P: begin
                  gain_p_ff <= csr_wdata[15:0];
                  integ_ff  <= '0;
               end
               REG_GAIN_I: begin
                  gain_i_ff <= csr_wdata[15:0];
                  integ_ff  <= '0;
               end
               REG_GAIN_D: begin
                  gain_d_ff <= csr_wdata[15:0];
                  integ_ff  <= '0;
               end
               REG_GAIN_DRV: gain_drv_ff <= csr_wdata[15:0];
               REG_TARGET_X: target_x_ff <= csr_wdata;
               REG_TARGET_Y: target_y_ff <= csr_wdata;
               default: ;
            endcase
         end
         // integral saturates at the 48-bit limits
         if (state_ff == S_PID_ACC) begin
            if (isum[48] != isum[47]) begin
               integ_ff <= isum[48] ? INTEG_MIN : INTEG_MAX;
            end else begin
               integ_ff <= isum[47:0];
            end
            prev_err_ff <= err_ff;
         end
         // response register
         if (state_ff == S_OUT && out_free) begin
            rsp_tvalid_ff <= 1'b1;
            if (!stop_ff) last_us_ff <= ts_ff;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               dx_ff <= dx_acc;
               dy_ff <= dy_acc;
               hd_ff <= hd_acc;
               ts_ff <= in_ts;
            end
         end
         S_PREP: begin
            cx_ff   <= $signed({3'b000, ax, 30'b0});
            cy_ff   <= $signed({3'b000, ay, 30'b0});
            cz_ff   <= '0;
            iter_ff <= '0;
         end
         S_CORDIC: begin
            if (!cy_ff[57]) begin
               cx_ff <= cx_ff + shy;
               cy_ff <= cy_ff - shx;
               cz_ff <= cz_ff + atan_ext;
            end else begin
               cx_ff <= cx_ff - shy;
               cy_ff <= cy_ff + shx;
               cz_ff <= cz_ff - atan_ext;
            end
            iter_ff <= iter_ff + 1'b1;
         end
         S_ANGLE: bearing_ff <= bearing_acc;
         S_ERROR: begin
            err_ff     <= $signed(err_wide[8:0]);
            aligned_ff <= (dif < 18'sd768) && (dif > -18'sd768);
            dt_ff      <= ts_ff - last_us_ff;
         end
         S_SQ_X: sq_ff <= sq_prod;
         S_SQ_Y: sq_ff <= sq_ff + sq_prod;
         S_PID_MUL: begin
            errdt_ff <= err_ff * $signed({1'b0, dt_ff});
            pterm_ff <= gain_p_ff * err_ff;
            dd_ff    <= gain_d_ff * de;
         end
         S_PID_ACC: dnum_ff <= dd_ff * 21'sd1000000;
         S_PROD_LO: prod_ff <= {{23{prod_lo[40]}}, prod_lo};
         S_PROD_HI: prod_ff <= prod_ff + {prod_hi, 24'b0};
         S_DIVI_GO: ;
         S_DIVI_WAIT: begin
            if (div_done) begin
               iterm_ff <= q_signed;
               dterm_ff <= '0;
            end
         end
         S_DIVD_GO: ;
         S_DIVD_WAIT: if (div_done) dterm_ff <= q_signed;
         S_TURN: begin
            turn_ff  <= turn_acc;
            stop_ff  <= aligned_ff && (sq_ff <= NEAR_LIMIT);
            drive_ff <= '0;
            sqsh_ff  <= sq_ff;
            root_ff  <= '0;
            rem_ff   <= '0;
            iter_ff  <= '0;
         end
         S_SQRT: begin
            rem_ff  <= rfit ? rdiff[26:0] : remsh[26:0];
            root_ff <= {root_ff[23:0], rfit};
            sqsh_ff <= {sqsh_ff[47:0], 2'b00};
            iter_ff <= iter_ff + 1'b1;
         end
         S_DRIVE_MUL:  vprod_ff <= -$signed({vmul[41], vmul});
         S_DRIVE_CLIP: drive_ff <= vtrunc[10:0];
         S_MIX: begin
            if (stop_ff) begin
               lmix_ff <= '0;
               rmix_ff <= '0;
            end else begin
               lmix_ff <= (lsum > 12'sd512) ? 11'sd512 :
                          (lsum < -12'sd512) ? -11'sd512 : lsum[10:0];
               rmix_ff <= (rsum > 12'sd512) ? 11'sd512 :
                          (rsum < -12'sd512) ? -11'sd512 : rsum[10:0];
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_tdata_ff <= {stop_ff, err_ff, rmot[10], rmot[9:0], lmot[10], lmot[9:0]};
            end
         end
         default: ;
      endcase
   end

   hpdc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
